/* rtl/core/fcpa_pkg.sv */
`default_nettype none

package fcpa_pkg;

  // Address width of the pool and of the address ports.
  localparam int ADDR_BITS = 32;

  // Default depth of the free stack.
  localparam int DEF_MAX_CHUNKS = 1024;

  // Widths of the request and register fields.
  localparam int SIZE_W  = 17;
  localparam int TOTAL_W = 11;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // A rounded chunk can reach 2^17 bytes, so it needs one bit more than the size.
  localparam int CHUNK_W = SIZE_W + 1;

  // Request types.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 2'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_FALLBACK  = 3'd1,
    ST_FREED     = 3'd2,
    ST_ELSEWHERE = 3'd3,
    ST_NULL      = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_DOUBLE    = 3'd6,
    ST_INIT      = 3'd7
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    pop;
    logic    scan_start;
    logic    scan;
    logic    push;
    logic    init_start;
    logic    init_step;
    logic    init_finish;
    logic    set_res;
    logic    res_grant;
    status_t res_code;
    logic    load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       pool_enabled;
    logic       size_fits;
    logic       stack_empty;
    logic       addr_null;
    logic       out_of_range;
    logic       stack_full;
    logic       scan_hit;
    logic       scan_end;
    logic       init_end;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/fcpa_ctrl.sv */
`default_nettype none

module fcpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fcpa_pkg::dp_stat_t stat,
  output fcpa_pkg::dp_cmd_t      cmd
);
  import fcpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_SCAN,
    S_PUSH,
    S_POP,
    S_INIT,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  // A new request is taken only when no request is in flight.
  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_code = ST_FALLBACK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.req_type)
          REQ_ALLOC: begin
            if (stat.pool_enabled && stat.size_fits && !stat.stack_empty) begin
              cmd.pop    = 1'b1;
              state_next = S_POP;
            end else begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_FALLBACK;
              state_next   = S_RESULT;
            end
          end
          REQ_FREE: begin
            state_next = S_CHECK;
          end
          REQ_INIT: begin
            cmd.init_start = 1'b1;
            state_next     = S_INIT;
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_FALLBACK;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_CHECK: begin
        // The free checks run in a fixed order of priority.
        if (stat.addr_null) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NULL;
          state_next   = S_RESULT;
        end else if (!stat.pool_enabled || stat.out_of_range) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_ELSEWHERE;
          state_next   = S_RESULT;
        end else if (stat.stack_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OVERFLOW;
          state_next   = S_RESULT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DOUBLE;
          state_next   = S_RESULT;
        end else if (stat.scan_end) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push     = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_FREED;
        state_next   = S_RESULT;
      end
      S_POP: begin
        cmd.set_res   = 1'b1;
        cmd.res_grant = 1'b1;
        cmd.res_code  = ST_GRANTED;
        state_next    = S_RESULT;
      end
      S_INIT: begin
        if (stat.init_end) begin
          cmd.init_finish = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_code    = ST_INIT;
          state_next      = S_RESULT;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fcpa_dp.sv */
`default_nettype none

module fcpa_dp #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fcpa_pkg::dp_cmd_t                 cmd,
  output fcpa_pkg::dp_stat_t                     stat,
  input  wire logic [1:0]                        req_type,
  input  wire logic [fcpa_pkg::SIZE_W-1:0]       req_size,
  input  wire logic [fcpa_pkg::ADDR_BITS-1:0]    addr_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             status,
  output logic [fcpa_pkg::ADDR_BITS-1:0]         addr_out,
  output logic [$clog2(MAX_CHUNKS+1)-1:0]        free_left,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcpa_pkg::CFG_W-1:0]        cfg_data
);
  import fcpa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int SPAN_W = CHUNK_W + CNT_W;
  // The range compare runs at the wider of the offset and the span.
  localparam int CMP_W  = (ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W;

  // Configuration registers.
  logic [ADDR_BITS-1:0] pool_base;
  logic [SIZE_W-1:0]    chunk_bytes;
  logic [TOTAL_W-1:0]   chunk_total;
  logic                 pool_enabled;

  // Latched request and the pool geometry it sees.
  logic [1:0]           req_type_q;
  logic [SIZE_W-1:0]    req_size_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [CHUNK_W-1:0]   chunk_q;
  logic [CNT_W-1:0]     total_q;
  logic [SPAN_W-1:0]    span_q;

  // Free stack and its pointers.
  logic [ADDR_BITS-1:0] mem [MAX_CHUNKS];
  logic [ADDR_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [ADDR_BITS-1:0] init_addr;

  // Result held until the output register is free.
  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  status_t              out_status;

  logic [CHUNK_W-1:0]   chunk_round;
  logic [31:0]          total_wide;
  logic [ADDR_BITS-1:0] offset;
  logic                 scan_issue;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_idx;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ADDR_BITS-1:0] wr_data;
  logic [CNT_W-1:0]     count_dec;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      chunk_bytes  <= SIZE_W'(64);
      chunk_total  <= '0;
      pool_enabled <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POOL_BASE:    pool_base    <= cfg_data[ADDR_BITS-1:0];
        CFG_CHUNK_BYTES:  chunk_bytes  <= cfg_data[SIZE_W-1:0];
        CFG_CHUNK_TOTAL:  chunk_total  <= cfg_data[TOTAL_W-1:0];
        CFG_POOL_ENABLED: pool_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Chunk size rounded up to a multiple of 8 bytes and chunk count clamped to the stack depth.
  always_comb begin
    chunk_round = (CHUNK_W'(chunk_bytes) + CHUNK_W'(7)) & ~CHUNK_W'(7);
    total_wide  = (32'(chunk_total) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS)
                                                        : 32'(chunk_total);
  end

  // Request latch; the pool span is registered from the latched chunk size and count.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_q <= req_type;
      req_size_q <= req_size;
      addr_q     <= addr_in;
      chunk_q    <= chunk_round;
      total_q    <= total_wide[CNT_W-1:0];
    end
    span_q <= SPAN_W'(chunk_q) * SPAN_W'(total_q);
  end

  // Status toward the controller.
  assign offset     = addr_q - pool_base;
  assign scan_issue = cmd.scan && (idx < count);
  always_comb begin
    stat.req_type     = req_type_q;
    stat.pool_enabled = pool_enabled;
    stat.size_fits    = (CHUNK_W'(req_size_q) <= chunk_q);
    stat.stack_empty  = (count == '0);
    stat.addr_null    = (addr_q == '0);
    stat.out_of_range = (addr_q < pool_base) || (CMP_W'(offset) >= CMP_W'(span_q));
    stat.stack_full   = (count >= total_q);
    stat.scan_hit     = rd_vld && (rd_data == addr_q);
    stat.scan_end     = !rd_vld && (idx >= count);
    stat.init_end     = (idx >= total_q);
    stat.out_free     = !out_valid || !out_stall;
  end

  // Memory port selection: a pop or a scan reads, a push or an init walk writes.
  assign count_dec = count - CNT_W'(1);
  always_comb begin
    rd_en   = cmd.pop || scan_issue;
    rd_idx  = cmd.pop ? count_dec[IDX_W-1:0] : idx[IDX_W-1:0];
    wr_en   = cmd.push || cmd.init_step;
    wr_idx  = cmd.push ? count[IDX_W-1:0] : idx[IDX_W-1:0];
    wr_data = cmd.push ? addr_q : init_addr;
  end

  // Free stack storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Stack count, walk index and init address accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.pop) begin
        count <= count_dec;
      end else if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.init_finish) begin
        count <= total_q;
      end
      if (cmd.scan_start) begin
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= scan_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.init_start) begin
      idx <= '0;
    end else if (scan_issue || cmd.init_step) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.init_start) begin
      init_addr <= pool_base;
    end else if (cmd.init_step) begin
      init_addr <= init_addr + ADDR_BITS'(chunk_q);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_addr   <= cmd.res_grant ? rd_data : '0;
    end
  end

  // Output register; a new result may load in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      addr_out   <= res_addr;
      free_left  <= count;
    end
  end

  assign status = out_status;

endmodule

`default_nettype wire

/* rtl/core/fixed_chunk_pool_allocator_unit.sv */
`default_nettype none

// Fixed-size chunk pool allocator. A LIFO stack of free chunk addresses serves
// alloc requests (type 0), takes back freed chunks (type 1) after null, enable,
// range, full and double-free checks, and is refilled with every chunk of the
// pool by an init request (type 2); any other type answers fallback. Each
// request gives one result with a status, the granted address and the number
// of free chunks left. Requests are handled one at a time. A free that reaches
// the double-free scan reads one stacked entry per cycle through the single
// read port of the stack memory, and an init writes one stack entry per cycle.
// A new request is accepted while the previous result still waits at the
// output. No clearing pass runs after reset. Configuration registers
// (pool_base, chunk_bytes, chunk_total, pool_enabled) must be written only
// while no request is in flight; the block itself does not enforce this.
// chunk_bytes is rounded up to a multiple of 8 and chunk_total is clamped to
// the stack depth.
module fixed_chunk_pool_allocator_unit #(
  parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        req_type,
  input  wire logic [fcpa_pkg::SIZE_W-1:0]       req_size,
  input  wire logic [fcpa_pkg::ADDR_BITS-1:0]    addr_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             status,
  output logic [fcpa_pkg::ADDR_BITS-1:0]         addr_out,
  output logic [$clog2(MAX_CHUNKS+1)-1:0]        free_left,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcpa_pkg::CFG_W-1:0]        cfg_data
);
  import fcpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for one request at a time.
  fcpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stack memory, checks, configuration and output register.
  fcpa_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req_type),
    .req_size  (req_size),
    .addr_in   (addr_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .addr_out  (addr_out),
    .free_left (free_left),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

/* verif/tb_fixed_chunk_pool_allocator_unit.sv */
module tb_fixed_chunk_pool_allocator_unit;
  import fcpa_pkg::*;

  localparam int DEPTH = DEF_MAX_CHUNKS;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP = 40;

  // The block answers this request type with fallback and changes nothing.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    status_t              code;
    logic [ADDR_BITS-1:0] addr;
    logic [TOTAL_W-1:0]   left;
  } pool_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             req_type = REQ_ALLOC;
  logic [SIZE_W-1:0]      req_size = '0;
  logic [ADDR_BITS-1:0]   addr_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             status;
  logic [ADDR_BITS-1:0]   addr_out;
  logic [TOTAL_W-1:0]     free_left;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_POOL_BASE;
  logic [CFG_W-1:0]       cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Shadow copy of the pool registers and of the free stack.
  logic [ADDR_BITS-1:0] shadow_base = '0;
  logic [SIZE_W-1:0]    shadow_chunk_bytes = 17'd64;
  logic [TOTAL_W-1:0]   shadow_total = '0;
  logic                 shadow_enabled = 1'b1;
  logic [ADDR_BITS-1:0] pool_stack [DEPTH];
  int                   stack_fill = 0;

  // Addresses granted and not yet handed back, and results still owed.
  logic [ADDR_BITS-1:0] handed_out [$];
  pool_result_t         expected_results [$];
  pool_result_t         oldest;

  fixed_chunk_pool_allocator_unit #(
    .MAX_CHUNKS(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .req_size(req_size),
    .addr_in(addr_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .addr_out(addr_out),
    .free_left(free_left),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random backpressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
  endtask

  // Chunk size rounded up to a multiple of 8 bytes.
  function automatic longint unsigned chunk_stride();
    return (64'(shadow_chunk_bytes) + 64'd7) & ~64'd7;
  endfunction

  // The chunk count never exceeds the stack depth.
  function automatic int active_chunks();
    return (shadow_total > DEPTH) ? DEPTH : int'(shadow_total);
  endfunction

  // Applies one request to the shadow pool and returns the result it owes.
  function automatic pool_result_t predict_pool(input logic [1:0] kind,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [ADDR_BITS-1:0] addr);
    pool_result_t         res;
    longint unsigned      chunk;
    longint unsigned      span;
    logic [ADDR_BITS-1:0] offset;
    int                   total;
    bit                   seen;
    chunk = chunk_stride();
    total = active_chunks();
    span = chunk * 64'(total);
    offset = addr - shadow_base;
    seen = 1'b0;
    res.code = ST_FALLBACK;
    res.addr = '0;
    case (kind)
      REQ_ALLOC: begin
        if (shadow_enabled && 64'(size) <= chunk && stack_fill != 0) begin
          stack_fill--;
          res.addr = pool_stack[stack_fill];
          res.code = ST_GRANTED;
          handed_out.push_back(res.addr);
        end
      end
      REQ_FREE: begin
        if (addr == '0) begin
          res.code = ST_NULL;
        end else if (!shadow_enabled) begin
          res.code = ST_ELSEWHERE;
        end else if (addr < shadow_base || 64'(offset) >= span) begin
          res.code = ST_ELSEWHERE;
        end else if (stack_fill >= total) begin
          res.code = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < stack_fill; i++)
            if (pool_stack[i] == addr) seen = 1'b1;
          if (seen) begin
            res.code = ST_DOUBLE;
          end else begin
            pool_stack[stack_fill] = addr;
            stack_fill++;
            res.code = ST_FREED;
          end
        end
      end
      REQ_INIT: begin
        for (int i = 0; i < total; i++)
          pool_stack[i] = shadow_base + ADDR_BITS'(64'(i) * chunk);
        stack_fill = total;
        handed_out.delete();
        res.code = ST_INIT;
      end
      default: ;
    endcase
    res.left = TOTAL_W'(stack_fill);
    return res;
  endfunction

  // Check every delivered result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(status), '0);
      end else begin
        oldest = expected_results.pop_front();
        if (status !== oldest.code)
          report_mismatch("status", 32'(status), 32'(oldest.code));
        if (addr_out !== oldest.addr)
          report_mismatch("addr_out", addr_out, oldest.addr);
        if (free_left !== oldest.left)
          report_mismatch("free_left", 32'(free_left), 32'(oldest.left));
      end
    end
  end

  // Sends one request, with random gaps ahead of it, and records its result.
  task automatic send_req(input logic [1:0] kind, input logic [SIZE_W-1:0] size,
                          input logic [ADDR_BITS-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    req_size <= size;
    addr_in <= addr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_results.push_back(predict_pool(kind, size, addr));
  endtask

  // Holds off requests until every result is in and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the valid stays up for back-to-back writes.
  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_POOL_BASE:    shadow_base = value;
      CFG_CHUNK_BYTES:  shadow_chunk_bytes = value[SIZE_W-1:0];
      CFG_CHUNK_TOTAL:  shadow_total = value[TOTAL_W-1:0];
      CFG_POOL_ENABLED: shadow_enabled = value[0];
      default: ;
    endcase
  endtask

  // Writes the registers selected by the mask, bit i for register index i.
  task automatic write_regs(input logic [3:0] mask, input logic [ADDR_BITS-1:0] base,
                            input logic [SIZE_W-1:0] cbytes, input logic [TOTAL_W-1:0] total,
                            input logic en);
    if (mask[CFG_POOL_BASE]) write_one(CFG_POOL_BASE, base);
    if (mask[CFG_CHUNK_BYTES]) write_one(CFG_CHUNK_BYTES, CFG_W'(cbytes));
    if (mask[CFG_CHUNK_TOTAL]) write_one(CFG_CHUNK_TOTAL, CFG_W'(total));
    if (mask[CFG_POOL_ENABLED]) write_one(CFG_POOL_ENABLED, CFG_W'(en));
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: no chunks at all, so nothing can be granted or freed.
  task automatic test_empty_pool();
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_FREE, '0, '0);
    send_req(REQ_FREE, '0, 32'h40);
    send_req(REQ_INIT, '0, '0);
  endtask

  // A small pool of four 16-byte chunks walked through every outcome but a null free.
  task automatic test_alloc_free_cycle();
    wait_idle();
    write_regs(4'b0111, 32'h1000, 17'd13, 11'd4, 1'b1);
    send_req(REQ_INIT, '0, '0);
    send_req(REQ_ALLOC, 17'd16, '1);
    send_req(REQ_ALLOC, 17'd17, '0);
    send_req(REQ_FREE, '0, 32'h1030);
    // The stack is full again, so a second free is dropped.
    send_req(REQ_FREE, '0, 32'h1030);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_FREE, '1, 32'h1010);
    send_req(REQ_FREE, '0, 32'h1040);
    send_req(REQ_FREE, '0, 32'h0fff);
    send_req(REQ_UNUSED, '1, '1);
    // An unaligned address inside the range is still taken back.
    send_req(REQ_FREE, '0, 32'h1031);
    repeat (5) send_req(REQ_ALLOC, 17'd16, '0);
  endtask

  // A disabled pool answers allocs with fallback and frees with elsewhere or null, but init still runs.
  task automatic test_disabled_pool();
    wait_idle();
    write_regs(4'b1000, '0, '0, '0, 1'b0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_FREE, '0, 32'h1000);
    send_req(REQ_FREE, '0, '0);
    send_req(REQ_INIT, '0, '0);
  endtask

  // Zero-byte chunks at the top of the address space, count clamped to depth.
  task automatic test_degenerate_config();
    wait_idle();
    write_regs(4'b1111, '1, '0, '1, 1'b1);
    send_req(REQ_INIT, '0, '0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, 17'd1, '0);
    send_req(REQ_FREE, '0, '1);
  endtask

  // Mostly alloc/free pairs on live chunks, with some noise mixed in.
  task automatic send_random_req();
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
    longint unsigned      chunk;
    longint unsigned      span;
    int                   pick;
    int                   slot;
    chunk = chunk_stride();
    span = chunk * 64'(active_chunks());
    addr = $urandom;
    size = SIZE_W'($urandom_range(0, 17'h1ffff));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) != 0 && chunk < 64'h1ffff)
        size = SIZE_W'($urandom_range(0, int'(chunk) + 1));
      send_req(REQ_ALLOC, size, addr);
    end else if (pick < 80) begin
      if (handed_out.size() != 0) begin
        slot = $urandom_range(0, handed_out.size() - 1);
        addr = handed_out[slot];
        handed_out.delete(slot);
      end else if (span != 0) begin
        addr = shadow_base + ADDR_BITS'(64'($urandom) % span);
      end
      send_req(REQ_FREE, size, addr);
    end else if (pick < 87) begin
      // Hand back a chunk that is already on the stack.
      if (stack_fill != 0) addr = pool_stack[$urandom_range(0, stack_fill - 1)];
      send_req(REQ_FREE, size, addr);
    end else if (pick < 94) begin
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = shadow_base - ADDR_BITS'(1);
        2: addr = shadow_base + ADDR_BITS'(span);
        default: ;
      endcase
      send_req(REQ_FREE, size, addr);
    end else if (pick < 97) begin
      send_req(REQ_INIT, size, addr);
    end else begin
      send_req(REQ_UNUSED, size, addr);
    end
  endtask

  // Four pool settings in a row under one idling pattern.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int first_flavor, input int n_items);
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    cbytes;
    logic [TOTAL_W-1:0]   total;
    logic                 en;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int c = 0; c < 4; c++) begin
      wait_idle();
      base = $urandom;
      cbytes = SIZE_W'($urandom_range(1, 100));
      total = TOTAL_W'($urandom_range(2, 20));
      en = 1'b1;
      case ((first_flavor + c) % 8)
        0: begin
          // Chunk addresses wrap past the top of the address space.
          base = 32'hffff_ffff - $urandom_range(0, 255);
          cbytes = 17'd64;
          total = TOTAL_W'($urandom_range(1, 8));
        end
        1: total = TOTAL_W'($urandom_range(1, 32));
        2: begin
          cbytes = $urandom_range(0, 1) ? 17'h1ffff : 17'd65536;
          total = TOTAL_W'($urandom_range(1, 16));
        end
        3: begin
          base = $urandom & 32'hffff_f000;
          cbytes = 17'd8;
          total = TOTAL_W'(DEPTH);
        end
        4: total = '0;
        5: en = 1'b0;
        default: base = $urandom & 32'hffff_ff00;
      endcase
      write_regs(4'b1111, base, cbytes, total, en);
      send_req(REQ_INIT, SIZE_W'($urandom_range(0, 17'h1ffff)), $urandom);
      for (int k = 0; k < n_items / 4; k++) begin
        if (c == 0 && k == n_items / 8) wait_idle();
        send_random_req();
      end
    end
  endtask

  initial begin
    send_idle_pct = 19;
    recv_stall_pct = 62;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pool();
    test_alloc_free_cycle();
    test_disabled_pool();
    test_degenerate_config();
    test_random_traffic(19, 62, 0, 132);
    test_random_traffic(62, 19, 4, 132);
    test_random_traffic(0, 0, $urandom_range(0, 7), 132);
    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* fixed_chunk_pool_allocator_unit.f */
rtl/core/fcpa_pkg.sv
rtl/core/fcpa_ctrl.sv
rtl/core/fcpa_dp.sv
rtl/core/fixed_chunk_pool_allocator_unit.sv
verif/tb_fixed_chunk_pool_allocator_unit.sv
